>>> hdl/lct_pkg.sv
// Package for the LFU cache table: widths, action and reset codes, controller state type
// and the command/status structs between controller and datapath. No dependencies.
package lct_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int CFG_W           = 5;

  localparam logic             ACT_GET     = 1'b0;
  localparam logic             ACT_PUT     = 1'b1;
  localparam logic [CFG_W-1:0] CFG_RESET   = 5'd16;
  localparam logic signed [DATA_W-1:0] MISS_VALUE = -32'sd1;
  localparam logic signed [DATA_W-1:0] PUT_VALUE  = 32'sd0;
  localparam logic [DATA_W-1:0] CNT_ONE    = 32'd1;
  localparam logic [DATA_W-1:0] CNT_MAX    = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN,
    ST_APPLY
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic look;
    logic scan_step;
    logic apply;
  } lct_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_put;
    logic found;
    logic full;
    logic scan_last;
  } lct_sts_t;

endpackage

>>> hdl/lct_if.sv
// Valid/ready channel interfaces for the LFU cache table: request, result and
// configuration. Depends on lct_pkg for the payload widths.
interface lct_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic signed [lct_pkg::DATA_W-1:0]   key;
  logic signed [lct_pkg::DATA_W-1:0]   write_value;

  modport source (output valid, action, key, write_value, input ready);
  modport sink   (input valid, action, key, write_value, output ready);
endinterface

interface lct_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit;
  logic signed [lct_pkg::DATA_W-1:0]   read_value;

  modport source (output valid, hit, read_value, input ready);
  modport sink   (input valid, hit, read_value, output ready);
endinterface

interface lct_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lct_pkg::CFG_W-1:0]     active_entries;

  modport source (output valid, active_entries, input ready);
  modport sink   (input valid, active_entries, output ready);
endinterface

>>> hdl/lct_ctrl.sv
// Controller of the LFU cache table: sequences lookup, victim scan and update,
// and owns the result valid flag. Depends on lct_pkg.
module lct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lct_pkg::lct_sts_t sts,
  output lct_pkg::lct_cmd_t cmd
);
  import lct_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        commit;
  logic        accept;

  // The result register can take a new result when empty or being drained.
  assign commit = (state_r == ST_APPLY) && (!out_valid_r || out_ready);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_LOOK;
      end
      ST_LOOK: begin
        if (sts.is_put && !sts.found && sts.full) state_nxt = ST_SCAN;
        else state_nxt = ST_APPLY;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (commit) state_nxt = accept ? ST_LOOK : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    out_valid_nxt = out_valid_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_LOOK: begin
        cmd.look = 1'b1;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_APPLY: begin
        in_ready  = commit;
        cmd.apply = commit;
      end
      default: in_ready = 1'b0;
    endcase
    cmd.load_in = accept;
    if (commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOOK || state_r == ST_SCAN) |-> !in_ready)
    else $error("input taken while an item is in flight");

  a_scan_only_put: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> sts.is_put)
    else $error("victim scan started for a get");

  a_result_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> out_valid)
    else $error("result lost after update");

endmodule

>>> hdl/lct_datapath.sv
// Datapath of the LFU cache table: entry registers, parallel key match,
// one-entry-per-cycle victim scan, update logic and the result register. Depends on lct_pkg.
module lct_datapath #(
  parameter int MAX_ENTRIES = lct_pkg::MAX_ENTRIES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lct_pkg::lct_cmd_t                 cmd,
  output lct_pkg::lct_sts_t                 sts,
  input  logic                              in_action,
  input  logic signed [lct_pkg::DATA_W-1:0] in_key,
  input  logic signed [lct_pkg::DATA_W-1:0] in_write_value,
  input  logic                              cfg_we,
  input  logic [lct_pkg::CFG_W-1:0]         cfg_data,
  output logic                              out_hit,
  output logic signed [lct_pkg::DATA_W-1:0] out_read_value
);
  import lct_pkg::*;

  localparam int N    = MAX_ENTRIES;
  localparam int IW   = (N > 1) ? $clog2(N) : 1;
  localparam int OW   = $clog2(N + 1);
  localparam int CMPW = (OW > CFG_W) ? OW : CFG_W;

  // Captured request
  logic                     in_act_r;
  logic [DATA_W-1:0]        in_key_r;
  logic [DATA_W-1:0]        in_wval_r;

  // Entry store
  logic [N-1:0]             valid_r;
  logic [DATA_W-1:0]        key_r   [N];
  logic [DATA_W-1:0]        data_r  [N];
  logic [DATA_W-1:0]        cnt_r   [N];
  logic [DATA_W-1:0]        stamp_r [N];
  logic [DATA_W-1:0]        clock_r;
  logic [OW-1:0]            occ_r;
  logic [CFG_W-1:0]         act_r;

  // Lookup results
  logic                     found_r;
  logic [IW-1:0]            hit_idx_r;
  logic [IW-1:0]            free_idx_r;
  logic                     full_r;

  // Victim scan
  logic [IW-1:0]            scan_idx_r;
  logic                     best_ok_r;
  logic [IW-1:0]            best_idx_r;
  logic [DATA_W-1:0]        best_cnt_r;
  logic [DATA_W-1:0]        best_age_r;

  logic [N-1:0]             match;
  logic                     hit_any;
  logic [IW-1:0]            hit_idx;
  logic [IW-1:0]            free_idx;
  logic [CMPW-1:0]          cap;
  logic [CMPW-1:0]          cfg_ext;
  logic                     full_now;
  logic [DATA_W-1:0]        scan_cnt;
  logic [DATA_W-1:0]        scan_age;
  logic                     take;
  logic [IW-1:0]            slot_idx;
  logic                     do_insert;
  logic                     do_touch;
  logic [N-1:0]             ins_sel;
  logic [N-1:0]             touch_sel;

  // Parallel compare and lowest-index encoders for the hit and the first free slot.
  always_comb begin
    hit_any  = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < N; i++) begin
      match[i] = valid_r[i] && (key_r[i] == in_key_r);
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid_r[i]) free_idx = IW'(i);
    end
  end

  // Effective capacity: zero acts as one, anything above the store size is clamped.
  always_comb begin
    cfg_ext = CMPW'(act_r);
    if (cfg_ext == '0) cap = CMPW'(1);
    else if (cfg_ext > CMPW'(N)) cap = CMPW'(N);
    else cap = cfg_ext;
    full_now = CMPW'(occ_r) >= cap;
  end

  // Scan step: lower count wins, equal counts go to the older touch.
  always_comb begin
    scan_cnt = cnt_r[scan_idx_r];
    scan_age = clock_r - stamp_r[scan_idx_r];
    take = valid_r[scan_idx_r] &&
           (!best_ok_r || (scan_cnt < best_cnt_r) ||
            ((scan_cnt == best_cnt_r) && (scan_age > best_age_r)));
  end

  assign do_insert = cmd.apply && (in_act_r == ACT_PUT) && !found_r;
  assign do_touch  = cmd.apply && found_r;
  assign slot_idx  = full_r ? best_idx_r : free_idx_r;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ins_sel[i]   = do_insert && (slot_idx == IW'(i));
      touch_sel[i] = do_touch && (hit_idx_r == IW'(i));
    end
  end

  assign sts.is_put    = (in_act_r == ACT_PUT);
  assign sts.found     = hit_any;
  assign sts.full      = full_now;
  assign sts.scan_last = (scan_idx_r == IW'(N - 1));

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_act_r  <= in_action;
      in_key_r  <= in_key;
      in_wval_r <= in_write_value;
    end
    if (cmd.look) begin
      hit_idx_r  <= hit_idx;
      free_idx_r <= free_idx;
      full_r     <= full_now;
    end
    if (cmd.scan_step && take) begin
      best_idx_r <= scan_idx_r;
      best_cnt_r <= scan_cnt;
      best_age_r <= scan_age;
    end
    for (int i = 0; i < N; i++) begin
      if (ins_sel[i]) begin
        key_r[i]   <= in_key_r;
        data_r[i]  <= in_wval_r;
        cnt_r[i]   <= CNT_ONE;
        stamp_r[i] <= clock_r;
      end else if (touch_sel[i]) begin
        if (in_act_r == ACT_PUT) data_r[i] <= in_wval_r;
        if (cnt_r[i] != CNT_MAX) cnt_r[i] <= cnt_r[i] + CNT_ONE;
        stamp_r[i] <= clock_r;
      end
    end
    if (cmd.apply) begin
      out_hit <= found_r;
      if (in_act_r == ACT_PUT) out_read_value <= PUT_VALUE;
      else if (found_r) out_read_value <= data_r[hit_idx_r];
      else out_read_value <= MISS_VALUE;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      clock_r    <= '0;
      occ_r      <= '0;
      act_r      <= CFG_RESET;
      found_r    <= 1'b0;
      scan_idx_r <= '0;
      best_ok_r  <= 1'b0;
    end else begin
      if (cfg_we) act_r <= cfg_data;
      if (cmd.look) begin
        found_r    <= hit_any;
        scan_idx_r <= '0;
        best_ok_r  <= 1'b0;
      end
      if (cmd.scan_step) begin
        scan_idx_r <= scan_idx_r + IW'(1);
        if (take) best_ok_r <= 1'b1;
      end
      if (do_insert || do_touch) clock_r <= clock_r + CNT_ONE;
      if (do_insert) begin
        valid_r <= valid_r | ins_sel;
        if (!full_r) occ_r <= occ_r + OW'(1);
      end
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OW'(N))
    else $error("occupancy above store size");

  a_victim_exists: assert property (@(posedge clk) disable iff (!rst_n)
    (do_insert && full_r) |-> best_ok_r)
    else $error("evicting insert without a victim");

  a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_insert || do_touch) |=> (clock_r == $past(clock_r) + CNT_ONE))
    else $error("touch clock did not advance");

endmodule

>>> hdl/lfu_cache_table.sv
// Top level of the LFU cache table: channel interfaces, controller and datapath.
// Depends on lct_pkg, lct_if, lct_ctrl and lct_datapath.
//
// Usage: a request item on in_ch carries an action (get or put), a key and a write
// value. Each request gives exactly one result item on out_ch: hit tells whether the
// key was present, read_value carries the stored value on a get hit, all ones on a
// get miss and zero for a put. cfg_ch writes active_entries, the number of entries
// held before a put of a new key evicts; it is always ready and is meant to be
// written while no request is in flight.
// Timing: a request is looked up the cycle after acceptance; the update and result follow
// in the apply state once the output register is empty or being drained, and the next
// request can be accepted in the cycle the result is registered. A put of a new key
// into a full table adds a victim scan over all MAX_ENTRIES entries, one entry per cycle
// through a shared count/age comparator, between the lookup and the update.
// Reset clears every valid bit, the touch clock and the occupancy count at once, and
// sets active_entries to 16; no clearing pass is needed.
// A stalled result waits in the output register; one more request is taken and
// looked up meanwhile, and its update waits until the register drains.
module lfu_cache_table #(
  parameter int MAX_ENTRIES = lct_pkg::MAX_ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  lct_in_if.sink    in_ch,
  lct_out_if.source out_ch,
  lct_cfg_if.sink   cfg_ch
);
  import lct_pkg::*;

  lct_cmd_t cmd;
  lct_sts_t sts;

  // Configuration writes are taken in any cycle.
  assign cfg_ch.ready = 1'b1;

  lct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lct_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_action      (in_ch.action),
    .in_key         (in_ch.key),
    .in_write_value (in_ch.write_value),
    .cfg_we         (cfg_ch.valid),
    .cfg_data       (cfg_ch.active_entries),
    .out_hit        (out_ch.hit),
    .out_read_value (out_ch.read_value)
  );

endmodule
